// File: sv/cul_pkg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// cul_pkg
// Shared types and constants of the capture undo log table.
// ---------------------------------------------------------------------------
package cul_pkg;

  localparam int CUL_MAX_SLOTS   = 64;
  localparam int CUL_POS_WIDTH   = 32;
  localparam int CUL_QUEUE_DEPTH = 2;

  typedef enum logic [1:0] {
    ACT_START = 2'd0,
    ACT_END   = 2'd1,
    ACT_CLEAR = 2'd2,
    ACT_DUMP  = 2'd3
  } action_t;

  typedef enum logic {
    REG_ENABLE   = 1'b0,
    REG_CAPACITY = 1'b1
  } reg_index_t;

  typedef struct packed {
    action_t     act;
    logic [7:0]  capture;
    logic [31:0] pos;
    logic [6:0]  limit;
  } cmd_t;

  typedef struct packed {
    logic        present;
    logic [7:0]  capture;
    logic [31:0] start_pos;
    logic [31:0] end_pos;
    logic [6:0]  count;
    logic        last;
  } res_t;

endpackage

// File: sv/cul_ram.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// cul_ram
// Generic single-write, single-read RAM with registered read data.
// ---------------------------------------------------------------------------
module cul_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: sv/cul_fifo.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// cul_fifo
// Small synchronous queue with push/full and pop/empty.
// ---------------------------------------------------------------------------
module cul_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] wdata,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] rdata,
  output logic             empty
);

  localparam int PTR_W = DEPTH > 1 ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_push;
  logic             do_pop;

  assign full    = count == CNT_W'(DEPTH);
  assign empty   = count == '0;
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= wdata;
    end
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

// File: sv/cul_front.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// cul_front
// Accepts items, drops track actions that have no effect and queues the rest.
// ---------------------------------------------------------------------------
module cul_front import cul_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  output logic        full,
  input  logic [1:0]  action,
  input  logic [7:0]  capture_index,
  input  logic [31:0] old_position,
  input  logic [6:0]  dump_limit,
  input  logic        log_enable,
  input  logic [6:0]  log_capacity,
  input  logic        cmd_pop,
  output cmd_t        cmd,
  output logic        cmd_empty
);

  cmd_t item;
  logic is_track;
  logic keep;

  assign item.act     = action_t'(action);
  assign item.capture = capture_index;
  assign item.pos     = old_position;
  assign item.limit   = dump_limit;

  assign is_track = item.act == ACT_START || item.act == ACT_END;
  assign keep     = !is_track || (log_enable && log_capacity != '0);

  cul_fifo #(
    .WIDTH ($bits(cmd_t)),
    .DEPTH (CUL_QUEUE_DEPTH)
  ) u_cmd_q (
    .clk   (clk),
    .rst   (rst),
    .push  (push && keep),
    .wdata (item),
    .full  (full),
    .pop   (cmd_pop),
    .rdata (cmd),
    .empty (cmd_empty)
  );

endmodule

// File: sv/cul_back.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// cul_back
// Executes queued actions: tag search and slot update, clear, and dump.
// ---------------------------------------------------------------------------
module cul_back import cul_pkg::*; #(
  parameter int MAX_SLOTS = CUL_MAX_SLOTS,
  parameter int POS_WIDTH = CUL_POS_WIDTH
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       cmd_empty,
  input  cmd_t       cmd,
  output logic       cmd_pop,
  input  logic [6:0] log_capacity,
  input  logic       res_full,
  output logic       res_push,
  output res_t       res
);

  localparam int IDX_W  = MAX_SLOTS > 1 ? $clog2(MAX_SLOTS) : 1;
  localparam int CNT_W  = $clog2(MAX_SLOTS + 1);
  localparam int NCHUNK = (MAX_SLOTS + 7) / 8;
  localparam int CH_W   = NCHUNK > 1 ? $clog2(NCHUNK) : 1;
  localparam int PAD    = NCHUNK * 8;
  localparam logic [POS_WIDTH-1:0] SENT = {POS_WIDTH{1'b1}};

  typedef enum logic [2:0] {
    S_IDLE, S_MATCH, S_SELECT, S_COUNT, S_SCAN, S_EMIT, S_EMPTY
  } state_t;

  state_t               state;
  cmd_t                 cmd_r;
  logic [MAX_SLOTS-1:0] valid;
  logic [MAX_SLOTS-1:0] start_set;
  logic [MAX_SLOTS-1:0] end_set;
  logic [7:0]           tag [MAX_SLOTS];
  logic [CNT_W-1:0]     ptr;
  logic [MAX_SLOTS-1:0] match_r;
  logic [IDX_W-1:0]     srch;
  logic [CH_W-1:0]      chunk;
  logic [CNT_W-1:0]     total;
  logic [CNT_W-1:0]     target;
  logic [CNT_W-1:0]     emitted;
  logic [IDX_W-1:0]     idx;

  logic [CNT_W-1:0]     cap_eff;
  logic [MAX_SLOTS-1:0] cap_mask;
  logic [MAX_SLOTS-1:0] le_mask;
  logic [MAX_SLOTS-1:0] match_c;
  logic [MAX_SLOTS-1:0] mvec;
  logic [PAD-1:0]       mpad;
  logic [7:0]           chunk_bits;
  logic [3:0]           pc;
  logic [CNT_W-1:0]     total_next;
  logic [CNT_W-1:0]     srch_wide;
  logic [MAX_SLOTS-1:0] lo;
  logic                 found;
  logic [IDX_W-1:0]     sel;
  logic [IDX_W-1:0]     wslot;
  logic                 is_end;
  logic [POS_WIDTH-1:0] pos_in;
  logic [POS_WIDTH-1:0] wstart;
  logic [POS_WIDTH-1:0] wend;
  logic                 do_write;
  logic                 we_cap;
  logic                 we_start;
  logic                 we_end;
  logic                 last_emit;
  logic [7:0]           rd_cap;
  logic [POS_WIDTH-1:0] rd_start;
  logic [POS_WIDTH-1:0] rd_end;

  function automatic logic [IDX_W-1:0] highest(input logic [MAX_SLOTS-1:0] v);
    logic [IDX_W-1:0] r;
    r = '0;
    for (int i = 0; i < MAX_SLOTS; i++) begin
      if (v[i]) begin
        r = IDX_W'(i);
      end
    end
    return r;
  endfunction

  assign cap_eff = (log_capacity > 7'(MAX_SLOTS)) ? CNT_W'(MAX_SLOTS)
                                                  : log_capacity[CNT_W-1:0];

  always_comb begin
    for (int i = 0; i < MAX_SLOTS; i++) begin
      cap_mask[i] = CNT_W'(i) < cap_eff;
      le_mask[i]  = IDX_W'(i) <= srch;
      match_c[i]  = valid[i] && tag[i] == cmd_r.capture && cap_mask[i];
    end
  end

  assign mvec       = valid & (start_set | end_set) & cap_mask;
  assign mpad       = PAD'(mvec);
  assign chunk_bits = 8'(mpad >> {chunk, 3'b000});

  always_comb begin
    pc = '0;
    for (int i = 0; i < 8; i++) begin
      pc = pc + 4'(chunk_bits[i]);
    end
  end

  assign total_next = total + CNT_W'(pc);
  assign srch_wide  = (ptr != '0 && ptr <= cap_eff) ? ptr - 1'b1 : cap_eff - 1'b1;

  assign lo     = match_r & le_mask;
  assign found  = |match_r;
  assign sel    = (|lo) ? highest(lo) : highest(match_r);
  assign wslot  = found ? sel : ((ptr >= cap_eff) ? '0 : ptr[IDX_W-1:0]);
  assign is_end = cmd_r.act == ACT_END;
  assign pos_in = POS_WIDTH'(cmd_r.pos);
  assign wstart = (!found && is_end) ? SENT : pos_in;
  assign wend   = (!found && !is_end) ? SENT : pos_in;

  assign do_write = state == S_SELECT;
  assign we_cap   = do_write && !found;
  assign we_start = do_write && (!found || !is_end);
  assign we_end   = do_write && (!found || is_end);

  assign last_emit = (emitted + 1'b1) == target;

  assign cmd_pop  = state == S_IDLE && !cmd_empty;
  assign res_push = (state == S_EMIT || state == S_EMPTY) && !res_full;

  always_comb begin
    if (state == S_EMIT) begin
      res.present   = 1'b1;
      res.capture   = rd_cap;
      res.start_pos = 32'(rd_start);
      res.end_pos   = 32'(rd_end);
      res.last      = last_emit;
    end else begin
      res.present   = 1'b0;
      res.capture   = '0;
      res.start_pos = 32'(SENT);
      res.end_pos   = 32'(SENT);
      res.last      = 1'b1;
    end
    res.count = 7'(total);
  end

  cul_ram #(.WIDTH(8), .DEPTH(MAX_SLOTS)) u_cap_ram (
    .clk (clk), .we (we_cap), .waddr (wslot), .wdata (cmd_r.capture),
    .raddr (idx), .rdata (rd_cap)
  );

  cul_ram #(.WIDTH(POS_WIDTH), .DEPTH(MAX_SLOTS)) u_start_ram (
    .clk (clk), .we (we_start), .waddr (wslot), .wdata (wstart),
    .raddr (idx), .rdata (rd_start)
  );

  cul_ram #(.WIDTH(POS_WIDTH), .DEPTH(MAX_SLOTS)) u_end_ram (
    .clk (clk), .we (we_end), .waddr (wslot), .wdata (wend),
    .raddr (idx), .rdata (rd_end)
  );

  always_ff @(posedge clk) begin
    if (cmd_pop) begin
      cmd_r <= cmd;
    end
    if (we_cap) begin
      tag[wslot] <= cmd_r.capture;
    end
    if (we_start) begin
      start_set[wslot] <= wstart != SENT;
    end
    if (we_end) begin
      end_set[wslot] <= wend != SENT;
    end
    if (rst) begin
      state   <= S_IDLE;
      valid   <= '0;
      ptr     <= '0;
      match_r <= '0;
      srch    <= '0;
      chunk   <= '0;
      total   <= '0;
      target  <= '0;
      emitted <= '0;
      idx     <= '0;
    end else begin
      case (state)
        S_IDLE: begin
          if (!cmd_empty) begin
            case (cmd.act)
              ACT_CLEAR: begin
                valid <= '0;
                ptr   <= '0;
              end
              ACT_DUMP: begin
                chunk <= '0;
                total <= '0;
                state <= S_COUNT;
              end
              default: begin
                state <= S_MATCH;
              end
            endcase
          end
        end
        S_MATCH: begin
          match_r <= match_c;
          srch    <= srch_wide[IDX_W-1:0];
          state   <= S_SELECT;
        end
        S_SELECT: begin
          valid[wslot] <= 1'b1;
          if (!found) begin
            ptr <= (ptr >= cap_eff) ? CNT_W'(1) : ptr + 1'b1;
          end
          state <= S_IDLE;
        end
        S_COUNT: begin
          total <= total_next;
          chunk <= chunk + 1'b1;
          if (chunk == CH_W'(NCHUNK - 1)) begin
            target  <= (cmd_r.limit < 7'(total_next)) ? cmd_r.limit[CNT_W-1:0]
                                                       : total_next;
            emitted <= '0;
            idx     <= '0;
            if (cmd_r.limit == '0 || total_next == '0) begin
              state <= S_EMPTY;
            end else begin
              state <= S_SCAN;
            end
          end
        end
        S_SCAN: begin
          if (mvec[idx]) begin
            state <= S_EMIT;
          end else begin
            idx <= idx + 1'b1;
          end
        end
        S_EMIT: begin
          if (!res_full) begin
            emitted <= emitted + 1'b1;
            if (last_emit) begin
              state <= S_IDLE;
            end else begin
              idx   <= idx + 1'b1;
              state <= S_SCAN;
            end
          end
        end
        S_EMPTY: begin
          if (!res_full) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

// File: sv/capture_undo_log_table.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// capture_undo_log_table
// Ring-indexed undo log of capture-register positions with dump readout.
//
//   Channel   Handshake              Payload
//   input     push / full            action, capture_index, old_position,
//                                    dump_limit
//   result    empty / pop            entry_present, entry_capture, entry_start,
//                                    entry_end, meaningful_count, is_last
//   config    cfg_write              cfg_index, cfg_data
//
// A track item passes three steps in the back end: dequeue, tag compare over
// all slots, then priority select and the slot write. Clear acts on dequeue.
// A dump counts meaningful slots eight per cycle, then walks the slots one per
// cycle and enters an emit state per item for the RAM read, held on a full
// result queue. Reset is synchronous; no memory clearing pass is needed.
// A full result queue stalls only the back end; the front keeps queueing.
// ---------------------------------------------------------------------------
module capture_undo_log_table import cul_pkg::*; #(
  parameter int MAX_SLOTS = CUL_MAX_SLOTS,
  parameter int POS_WIDTH = CUL_POS_WIDTH
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  output logic        full,
  input  logic [1:0]  action,
  input  logic [7:0]  capture_index,
  input  logic [31:0] old_position,
  input  logic [6:0]  dump_limit,
  output logic        empty,
  input  logic        pop,
  output logic        entry_present,
  output logic [7:0]  entry_capture,
  output logic [31:0] entry_start,
  output logic [31:0] entry_end,
  output logic [6:0]  meaningful_count,
  output logic        is_last,
  input  logic        cfg_write,
  input  logic        cfg_index,
  input  logic [6:0]  cfg_data
);

  logic       log_enable;
  logic [6:0] log_capacity;
  cmd_t       cmd;
  logic       cmd_empty;
  logic       cmd_pop;
  res_t       res_in;
  res_t       res_out;
  logic       res_push;
  logic       res_full;

  always_ff @(posedge clk) begin
    if (rst) begin
      log_enable   <= 1'b0;
      log_capacity <= 7'd64;
    end else if (cfg_write) begin
      case (reg_index_t'(cfg_index))
        REG_ENABLE:   log_enable   <= cfg_data[0];
        REG_CAPACITY: log_capacity <= cfg_data;
        default:      log_enable   <= log_enable;
      endcase
    end
  end

  cul_front u_front (
    .clk           (clk),
    .rst           (rst),
    .push          (push),
    .full          (full),
    .action        (action),
    .capture_index (capture_index),
    .old_position  (old_position),
    .dump_limit    (dump_limit),
    .log_enable    (log_enable),
    .log_capacity  (log_capacity),
    .cmd_pop       (cmd_pop),
    .cmd           (cmd),
    .cmd_empty     (cmd_empty)
  );

  cul_back #(
    .MAX_SLOTS (MAX_SLOTS),
    .POS_WIDTH (POS_WIDTH)
  ) u_back (
    .clk          (clk),
    .rst          (rst),
    .cmd_empty    (cmd_empty),
    .cmd          (cmd),
    .cmd_pop      (cmd_pop),
    .log_capacity (log_capacity),
    .res_full     (res_full),
    .res_push     (res_push),
    .res          (res_in)
  );

  cul_fifo #(
    .WIDTH ($bits(res_t)),
    .DEPTH (CUL_QUEUE_DEPTH)
  ) u_res_q (
    .clk   (clk),
    .rst   (rst),
    .push  (res_push),
    .wdata (res_in),
    .full  (res_full),
    .pop   (pop),
    .rdata (res_out),
    .empty (empty)
  );

  assign entry_present    = res_out.present;
  assign entry_capture    = res_out.capture;
  assign entry_start      = res_out.start_pos;
  assign entry_end        = res_out.end_pos;
  assign meaningful_count = res_out.count;
  assign is_last          = res_out.last;

endmodule

// File: sv/cul_checker.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// cul_checker
// Port-level checks of the capture undo log table.
// ---------------------------------------------------------------------------
module cul_checker (
  input logic        clk,
  input logic        rst,
  input logic        empty,
  input logic        pop,
  input logic        entry_present,
  input logic [7:0]  entry_capture,
  input logic [31:0] entry_start,
  input logic [31:0] entry_end,
  input logic [6:0]  meaningful_count,
  input logic        is_last
);

  a_reset_empty: assert property (@(posedge clk) rst |=> empty)
    else $error("result queue not empty after reset");

  a_empty_item_last: assert property (@(posedge clk) disable iff (rst)
    (!empty && !entry_present) |-> is_last)
    else $error("empty dump item is not marked last");

  a_empty_item_fields: assert property (@(posedge clk) disable iff (rst)
    (!empty && !entry_present) |->
      (entry_capture == 8'd0 && entry_start == '1 && entry_end == '1))
    else $error("empty dump item carries entry fields");

  a_present_counted: assert property (@(posedge clk) disable iff (rst)
    (!empty && entry_present) |-> meaningful_count != 7'd0)
    else $error("entry emitted with zero meaningful count");

  a_result_holds: assert property (@(posedge clk) disable iff (rst)
    (!empty && !pop) |=> !empty)
    else $error("waiting item dropped");

endmodule

bind capture_undo_log_table cul_checker u_chk (.*);
